// ===== hdl/hpd_pkg.sv =====
// Shared types, constants and the rank function of the heap dispatcher.
// Used by every module of the block but hpd_ram; depends on nothing.
`default_nettype none

package hpd_pkg;

  // Default number of heap entries
  localparam int unsigned HPD_CAPACITY = 64;

  // Field widths
  localparam int unsigned ID_W    = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned CLOCK_W = 22;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned OCC_W   = 7;

  localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};

  // One heap entry, 48 bits
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } hpd_entry_t;

  localparam int unsigned ENTRY_W = $bits(hpd_entry_t);

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } hpd_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_TOP,
    S_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R
  } hpd_state_e;

  // Request to the time unit: advance by the popped entry's burst
  typedef struct packed {
    logic              adv;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
  } hpd_time_req_t;

  // Waiting and turnaround times of the popped entry
  typedef struct packed {
    logic [DIFF_W-1:0] wait_time;
    logic [DIFF_W-1:0] turnaround;
  } hpd_time_rsp_t;

  // a outranks b: higher priority, then shorter burst
  function automatic logic ranks_above(hpd_entry_t a, hpd_entry_t b);
    logic r;
    if (a.prio != b.prio) r = (a.prio > b.prio);
    else                  r = (a.burst < b.burst);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/heap_priority_dispatcher_core.sv =====
// Heap priority dispatcher: top level, joins sequencer, heap RAM and time unit.
// Depends on hpd_pkg, hpd_ram, hpd_time and hpd_ctrl.
//
// Insert and dispatch on a binary max-heap held in one synchronous RAM with
// a registered read port. An item is taken when start is high and busy is
// low; its single result beat appears on the result ports with done_o high
// for exactly one cycle and must be taken then. A refused insert or a
// dispatch on an empty heap returns its beat in the cycle after acceptance
// and leaves busy low. An insert sifts up, reading one parent per level and
// comparing it with the new entry. A dispatch reads the top entry; unless it
// empties the heap, it then reads the last entry and sifts it down, reading
// the left and right child of each level one after the other through the
// single read port. The RAM read-compare-write loop runs once per heap
// level; results appear in order with no overlap between items.
`default_nettype none

module heap_priority_dispatcher_core
  import hpd_pkg::*;
#(
  parameter int unsigned CAPACITY = HPD_CAPACITY
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                mode_i,
  input  wire logic [ID_W-1:0]     proc_id_i,
  input  wire logic [TIME_W-1:0]   arrival_i,
  input  wire logic [TIME_W-1:0]   burst_i,
  input  wire logic [PRIO_W-1:0]   prio_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [ID_W-1:0]          out_id_o,
  output logic [DIFF_W-1:0]        wait_time_o,
  output logic [DIFF_W-1:0]        turnaround_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  hpd_entry_t     entry_in;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  hpd_entry_t     ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;
  hpd_time_req_t  time_req;
  hpd_time_rsp_t  time_rsp;

  // pack the input beat into a heap entry
  assign entry_in = '{id: proc_id_i, arrival: arrival_i, burst: burst_i, prio: prio_i};
  assign ram_rdata = hpd_entry_t'(ram_rbits);

  hpd_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .entry_i     (entry_in),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .re_o        (ram_re),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata),
    .time_req_o  (time_req),
    .time_rsp_i  (time_rsp),
    .done_o      (done_o),
    .status_o    (status_o),
    .out_id_o    (out_id_o),
    .wait_time_o (wait_time_o),
    .turnaround_o(turnaround_o),
    .occupancy_o (occupancy_o)
  );

  hpd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rbits)
  );

  hpd_time u_time (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (time_req),
    .rsp_o (time_rsp)
  );

endmodule

`default_nettype wire

// ===== hdl/hpd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module hpd_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hpd_time.sv =====
// Time unit: current-time register, waiting and turnaround arithmetic.
// Depends on hpd_pkg.
`default_nettype none

module hpd_time
  import hpd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hpd_time_req_t req_i,
  output hpd_time_rsp_t      rsp_o
);

  logic [CLOCK_W-1:0] clock_q, clock_d;
  logic [DIFF_W-1:0]  wait_v;
  logic [DIFF_W:0]    turn_sum;
  logic [DIFF_W-1:0]  adv_sum;

  // wait = now - arrival, always fits 23 bits signed
  assign wait_v   = {1'b0, clock_q} - {{(DIFF_W-TIME_W){1'b0}}, req_i.arrival};
  // turnaround in 24 bits signed, clipped at the clock maximum
  assign turn_sum = {wait_v[DIFF_W-1], wait_v} + {{(DIFF_W+1-TIME_W){1'b0}}, req_i.burst};

  always_comb begin
    rsp_o.wait_time = wait_v;
    if (!turn_sum[DIFF_W] && turn_sum[DIFF_W-1:0] > {1'b0, CLOCK_MAX}) begin
      rsp_o.turnaround = {1'b0, CLOCK_MAX};
    end else begin
      rsp_o.turnaround = turn_sum[DIFF_W-1:0];
    end
  end

  // saturating advance of current time
  assign adv_sum = {1'b0, clock_q} + {{(DIFF_W-TIME_W){1'b0}}, req_i.burst};

  always_comb begin
    clock_d = clock_q;
    if (req_i.adv) begin
      clock_d = adv_sum[DIFF_W-1] ? CLOCK_MAX : adv_sum[CLOCK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
    end else begin
      clock_q <= clock_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hpd_ctrl.sv =====
// Heap sequencer: sift-up on insert, sift-down on dispatch, over one RAM.
// Depends on hpd_pkg; drives the heap RAM and the time unit.
`default_nettype none

module hpd_ctrl
  import hpd_pkg::*;
#(
  parameter int unsigned CAPACITY = HPD_CAPACITY
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        mode_i,
  input  wire hpd_entry_t                  entry_i,
  // heap RAM
  output logic                             we_o,
  output logic [$clog2(CAPACITY)-1:0]      waddr_o,
  output hpd_entry_t                       wdata_o,
  output logic                             re_o,
  output logic [$clog2(CAPACITY)-1:0]      raddr_o,
  input  wire hpd_entry_t                  rdata_i,
  // time unit
  output hpd_time_req_t                    time_req_o,
  input  wire hpd_time_rsp_t               time_rsp_i,
  // result beat
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [ID_W-1:0]                  out_id_o,
  output logic [DIFF_W-1:0]                wait_time_o,
  output logic [DIFF_W-1:0]                turnaround_o,
  output logic [OCC_W-1:0]                 occupancy_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 2;

  hpd_state_e       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    cidx_q, cidx_d;
  hpd_entry_t       elem_q, elem_d;
  hpd_entry_t       child_q, child_d;
  logic             done_q, done_d;
  hpd_status_e      stat_q, stat_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [DIFF_W-1:0] wait_q, wait_d, turn_q, turn_d;
  logic [OCC_W-1:0] occ_q, occ_d;

  // shared conditions
  logic             accept, full, empty, last_one;
  logic             up_root, up_move;
  logic [XW-1:0]    lc_x, rc_x, cnt_x;
  logic             lc_in, rc_in;
  hpd_entry_t       pick_ent;
  logic [AW-1:0]    pick_idx;
  logic             dn_move;
  logic [AW-1:0]    parent_idx;
  logic [CW-1:0]    count_m1;

  assign accept     = start && !busy;
  assign full       = (count_q == CW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign last_one   = (count_q == CW'(1));
  assign up_root    = (pos_q == '0);
  assign up_move    = ranks_above(elem_q, rdata_i);
  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign count_m1   = count_q - CW'(1);
  assign lc_x       = {1'b0, pos_q, 1'b1};
  assign rc_x       = lc_x + XW'(1);
  assign cnt_x      = XW'(count_q);
  assign lc_in      = lc_x < cnt_x;
  assign rc_in      = rc_x < cnt_x;

  // child selection: right only when it strictly outranks the left
  always_comb begin
    if (state_q == S_DN_R && ranks_above(rdata_i, child_q)) begin
      pick_ent = rdata_i;
      pick_idx = cidx_q + AW'(1);
    end else if (state_q == S_DN_R) begin
      pick_ent = child_q;
      pick_idx = cidx_q;
    end else begin
      pick_ent = rdata_i;
      pick_idx = lc_x[AW-1:0];
    end
  end
  assign dn_move = ranks_above(pick_ent, elem_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !mode_i && !full)     state_d = S_UP_CHK;
        else if (accept && mode_i && !empty) state_d = S_TOP;
      end
      S_UP_CHK: state_d = up_root ? S_IDLE : S_UP_CMP;
      S_UP_CMP: state_d = up_move ? S_UP_CHK : S_IDLE;
      S_TOP:    state_d = last_one ? S_IDLE : S_LAST;
      S_LAST:   state_d = S_DN_CHK;
      S_DN_CHK: state_d = lc_in ? S_DN_L : S_IDLE;
      S_DN_L: begin
        if (rc_in)        state_d = S_DN_R;
        else if (dn_move) state_d = S_DN_CHK;
        else              state_d = S_IDLE;
      end
      S_DN_R:   state_d = dn_move ? S_DN_CHK : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath, RAM access and result
  always_comb begin
    we_o       = 1'b0;
    waddr_o    = pos_q;
    wdata_o    = elem_q;
    re_o       = 1'b0;
    raddr_o    = '0;
    count_d    = count_q;
    pos_d      = pos_q;
    cidx_d     = cidx_q;
    elem_d     = elem_q;
    child_d    = child_q;
    done_d     = 1'b0;
    stat_d     = stat_q;
    id_d       = id_q;
    wait_d     = wait_q;
    turn_d     = turn_q;
    occ_d      = occ_q;
    time_req_o = '{adv: 1'b0, arrival: rdata_i.arrival, burst: rdata_i.burst};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          stat_d = STATUS_OK;
          id_d   = '0;
          wait_d = '0;
          turn_d = '0;
          if (!mode_i && full) begin
            stat_d = STATUS_FULL;
            done_d = 1'b1;
            occ_d  = OCC_W'(count_q);
          end else if (mode_i && empty) begin
            stat_d = STATUS_EMPTY;
            done_d = 1'b1;
            occ_d  = '0;
          end else if (!mode_i) begin
            elem_d  = entry_i;
            pos_d   = count_q[AW-1:0];
            count_d = count_q + CW'(1);
          end else begin
            re_o    = 1'b1;
            raddr_o = '0;
          end
        end
      end
      S_UP_CHK: begin
        if (up_root) begin
          we_o   = 1'b1;
          done_d = 1'b1;
          occ_d  = OCC_W'(count_q);
        end else begin
          re_o    = 1'b1;
          raddr_o = parent_idx;
        end
      end
      S_UP_CMP: begin
        we_o = 1'b1;
        if (up_move) begin
          wdata_o = rdata_i;
          pos_d   = parent_idx;
        end else begin
          done_d = 1'b1;
          occ_d  = OCC_W'(count_q);
        end
      end
      S_TOP: begin
        // report the top entry and advance time
        time_req_o.adv = 1'b1;
        id_d    = rdata_i.id;
        wait_d  = time_rsp_i.wait_time;
        turn_d  = time_rsp_i.turnaround;
        count_d = count_m1;
        re_o    = 1'b1;
        raddr_o = count_m1[AW-1:0];
        if (last_one) begin
          done_d = 1'b1;
          occ_d  = OCC_W'(count_m1);
        end
      end
      S_LAST: begin
        elem_d = rdata_i;
        pos_d  = '0;
      end
      S_DN_CHK: begin
        if (lc_in) begin
          re_o    = 1'b1;
          raddr_o = lc_x[AW-1:0];
        end else begin
          we_o   = 1'b1;
          done_d = 1'b1;
          occ_d  = OCC_W'(count_q);
        end
      end
      S_DN_L: begin
        child_d = rdata_i;
        cidx_d  = lc_x[AW-1:0];
        if (rc_in) begin
          re_o    = 1'b1;
          raddr_o = rc_x[AW-1:0];
        end else begin
          we_o = 1'b1;
          if (dn_move) begin
            wdata_o = pick_ent;
            pos_d   = pick_idx;
          end else begin
            done_d = 1'b1;
            occ_d  = OCC_W'(count_q);
          end
        end
      end
      S_DN_R: begin
        we_o = 1'b1;
        if (dn_move) begin
          wdata_o = pick_ent;
          pos_d   = pick_idx;
        end else begin
          done_d = 1'b1;
          occ_d  = OCC_W'(count_q);
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cidx_q  <= cidx_d;
    elem_q  <= elem_d;
    child_q <= child_d;
    stat_q  <= stat_d;
    id_q    <= id_d;
    wait_q  <= wait_d;
    turn_q  <= turn_d;
    occ_q   <= occ_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = stat_q;
  assign out_id_o     = id_q;
  assign wait_time_o  = wait_q;
  assign turnaround_o = turn_q;
  assign occupancy_o  = occ_q;

  // heap never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // RAM writes stay inside the live part of the heap
  a_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> (CW'(waddr_o) < count_q))
    else $error("heap write beyond entry count");

  // an accepted insert with room grows the heap by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !mode_i && !full) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the heap");

  // a result beat only follows work in progress or an accepted item
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy || start))
    else $error("result beat without a cause");

endmodule

`default_nettype wire

// ===== tb/heap_priority_dispatcher_core_test.sv =====
// Self-checking testbench for heap_priority_dispatcher_core: a scoreboard keeps
// its own heap and clock and predicts every result beat of insert and dispatch.
// Depends on hpd_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module heap_priority_dispatcher_core_test;
  import hpd_pkg::*;

  localparam int unsigned DEPTH        = HPD_CAPACITY;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_LIMIT = 40;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned MAX_GAP      = 17;

  // Item modes
  localparam logic MODE_INSERT   = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  // One result beat, expected or observed
  typedef struct {
    logic [1:0]        status;
    logic [ID_W-1:0]   proc_id;
    logic [DIFF_W-1:0] wait_time;
    logic [DIFF_W-1:0] turnaround;
    logic [OCC_W-1:0]  occupancy;
  } dispatch_result_t;

  // Keeps a private heap and clock, queues the predicted beats
  class dispatch_scoreboard;
    hpd_entry_t         heap [DEPTH];
    int unsigned        fill;
    logic [CLOCK_W-1:0] now_clk;
    dispatch_result_t   pending_results [$];
    int unsigned        errors;

    function new();
      fill    = 0;
      now_clk = '0;
      errors  = 0;
    endfunction

    // Higher priority first, shorter burst on equal priority
    function bit outranks(hpd_entry_t a, hpd_entry_t b);
      if (a.prio != b.prio) return a.prio > b.prio;
      return a.burst < b.burst;
    endfunction

    function void swap_slots(int unsigned i, int unsigned j);
      hpd_entry_t t;
      t       = heap[i];
      heap[i] = heap[j];
      heap[j] = t;
    endfunction

    function void sift_up(int unsigned pos);
      int unsigned up;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (!outranks(heap[pos], heap[up])) break;
        swap_slots(pos, up);
        pos = up;
      end
    endfunction

    // Left child wins a tie between children; equal rank stops the walk
    function void sift_down();
      int unsigned pos, lc, pick;
      pos = 0;
      while (1) begin
        lc = 2 * pos + 1;
        if (lc >= fill) break;
        pick = lc;
        if (lc + 1 < fill && outranks(heap[lc + 1], heap[lc])) pick = lc + 1;
        if (!outranks(heap[pick], heap[pos])) break;
        swap_slots(pos, pick);
        pos = pick;
      end
    endfunction

    // Accepted input beat: update the heap and queue the expected result
    function void note_item(logic mode, hpd_entry_t e);
      dispatch_result_t   r;
      hpd_entry_t         top;
      int                 w, t;
      logic [CLOCK_W:0]   sum;
      r.status     = STATUS_OK;
      r.proc_id    = '0;
      r.wait_time  = '0;
      r.turnaround = '0;
      if (mode == MODE_INSERT) begin
        if (fill >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          heap[fill] = e;
          fill++;
          sift_up(fill - 1);
        end
      end else if (fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        top = heap[0];
        fill--;
        heap[0] = heap[fill];
        sift_down();
        w = int'(now_clk) - int'(top.arrival);
        t = w + int'(top.burst);
        if (t > int'(CLOCK_MAX)) t = int'(CLOCK_MAX);
        r.proc_id    = top.id;
        r.wait_time  = w[DIFF_W-1:0];
        r.turnaround = t[DIFF_W-1:0];
        sum = {1'b0, now_clk} + top.burst;
        now_clk = (sum > CLOCK_MAX) ? CLOCK_MAX : sum[CLOCK_W-1:0];
      end
      r.occupancy = fill[OCC_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned expv, int unsigned actv);
      if (expv != actv) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, expv, actv);
        errors++;
      end
    endfunction

    // Result beat: compare against the oldest prediction
    function void check_beat(dispatch_result_t got);
      dispatch_result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual status %0d id 0x%0h",
                 $time, got.status, got.proc_id);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      compare_field("status", exp.status, got.status);
      compare_field("out_id", exp.proc_id, got.proc_id);
      compare_field("wait_time", exp.wait_time, got.wait_time);
      compare_field("turnaround", exp.turnaround, got.turnaround);
      compare_field("occupancy", exp.occupancy, got.occupancy);
    endfunction
  endclass

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               start     = 1'b0;
  logic               mode_i    = MODE_INSERT;
  logic [ID_W-1:0]    proc_id_i = '0;
  logic [TIME_W-1:0]  arrival_i = '0;
  logic [TIME_W-1:0]  burst_i   = '0;
  logic [PRIO_W-1:0]  prio_i    = '0;
  logic               busy;
  logic               done_o;
  logic [1:0]         status_o;
  logic [ID_W-1:0]    out_id_o;
  logic [DIFF_W-1:0]  wait_time_o;
  logic [DIFF_W-1:0]  turnaround_o;
  logic [OCC_W-1:0]   occupancy_o;

  dispatch_scoreboard sb;
  int unsigned        idle_cycles = 0;

  heap_priority_dispatcher_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .proc_id_i    (proc_id_i),
    .arrival_i    (arrival_i),
    .burst_i      (burst_i),
    .prio_i       (prio_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .out_id_o     (out_id_o),
    .wait_time_o  (wait_time_o),
    .turnaround_o (turnaround_o),
    .occupancy_o  (occupancy_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Monitor: check the result beat first, then note the accepted input beat
  always @(posedge clk_i) begin : beat_monitor
    dispatch_result_t seen;
    if (rst_ni) begin
      if (done_o) begin
        seen.status     = status_o;
        seen.proc_id    = out_id_o;
        seen.wait_time  = wait_time_o;
        seen.turnaround = turnaround_o;
        seen.occupancy  = occupancy_o;
        sb.check_beat(seen);
      end
      if (start && !busy)
        sb.note_item(mode_i, {proc_id_i, arrival_i, burst_i, prio_i});
    end
  end

  // Watchdog on cycles with no beat in either direction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  function automatic hpd_entry_t make_entry(logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
                                            logic [TIME_W-1:0] len, logic [PRIO_W-1:0] pr);
    hpd_entry_t e;
    e.id      = id;
    e.arrival = arr;
    e.burst   = len;
    e.prio    = pr;
    return e;
  endfunction

  // Narrow the priority range half the time and the burst range most of the time to force ties
  function automatic hpd_entry_t random_entry();
    hpd_entry_t e;
    e.id      = ID_W'($urandom);
    e.arrival = $urandom_range(0, 1) ? TIME_W'($urandom_range(0, 1023)) : TIME_W'($urandom);
    e.burst   = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom)
                                             : TIME_W'($urandom_range(0, 255));
    e.prio    = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
    return e;
  endfunction

  // Drive one input beat after a random gap and hold it until accepted
  task automatic send_item(input logic mode, input hpd_entry_t e, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    mode_i    <= mode;
    proc_id_i <= e.id;
    arrival_i <= e.arrival;
    burst_i   <= e.burst;
    prio_i    <= e.prio;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off the sender until every predicted beat has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent, phase, count, ins_pct;
    bit          calm;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty dispatch, field extremes, rank ties, negative wait
    send_item(MODE_DISPATCH, make_entry(8'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_item(MODE_INSERT, make_entry(8'd1, 16'd100, 16'd10, 8'd5), 1'b0);
    send_item(MODE_INSERT, make_entry(8'd2, 16'd0, 16'd20, 8'd5), 1'b0);
    send_item(MODE_INSERT, make_entry(8'd3, 16'd0, 16'd10, 8'd5), 1'b0);
    send_item(MODE_INSERT, make_entry(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0);
    send_item(MODE_INSERT, make_entry(8'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_item(MODE_INSERT, make_entry(8'hAA, 16'h5555, 16'hAAAA, 8'h55), 1'b0);
    send_item(MODE_INSERT, make_entry(8'h55, 16'hAAAA, 16'h5555, 8'hAA), 1'b0);
    send_item(MODE_INSERT, make_entry(8'd9, 16'd0, 16'd3, 8'd9), 1'b0);
    repeat (8) send_item(MODE_DISPATCH, random_entry(), 1'b0);
    send_item(MODE_DISPATCH, random_entry(), 1'b1);
    // Equal children: the left one must move up
    send_item(MODE_INSERT, make_entry(8'd20, 16'd0, 16'd5, 8'd9), 1'b0);
    send_item(MODE_INSERT, make_entry(8'd21, 16'd0, 16'd3, 8'd4), 1'b0);
    send_item(MODE_INSERT, make_entry(8'd22, 16'd0, 16'd3, 8'd4), 1'b0);
    send_item(MODE_INSERT, make_entry(8'd23, 16'd0, 16'd9, 8'd1), 1'b0);
    send_item(MODE_DISPATCH, random_entry(), 1'b0);
    send_item(MODE_DISPATCH, random_entry(), 1'b0);
    wait_drained();

    // Random phases: fill-heavy, drain-heavy and balanced traffic
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 3)
        0: ins_pct = 85;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      calm  = ($urandom_range(0, 4) == 0);
      count = $urandom_range(40, 120);
      repeat (count) begin
        send_item(($urandom_range(1, 100) > ins_pct) ? MODE_DISPATCH : MODE_INSERT,
                  random_entry(), calm);
        sent++;
      end
      wait_drained();
      phase++;
    end

    repeat (SETTLE_LIMIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
